// File: rtl/mau_pkg.sv
// Shared widths, operation codes and defaults for the matrix arithmetic unit.
package mau_pkg;

  // Field widths of the request and response transactions.
  localparam int FUNC_W  = 3;
  localparam int COORD_W = 2;
  localparam int DATA_W  = 32;

  // Default matrix size.
  localparam int DEFAULT_N = 4;

  // Operation codes carried in the func field.
  localparam logic [FUNC_W-1:0] FUNC_LOAD_LEFT  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_RIGHT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUM        = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DIFF       = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SCALE      = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_PRODUCT    = 3'd5;

endpackage

// File: rtl/mau_req_if.sv
// Request channel: loads and operation starts.
interface mau_req_if;
  logic                              valid;
  logic                              ready;
  logic [mau_pkg::FUNC_W-1:0]        func;
  logic [mau_pkg::COORD_W-1:0]       row;
  logic [mau_pkg::COORD_W-1:0]       col;
  logic signed [mau_pkg::DATA_W-1:0] value;

  modport source (output valid, output func, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input func, input row, input col, input value,
                  output ready);
endinterface

// File: rtl/mau_rsp_if.sv
// Response channel: result matrix entries in row-major order.
interface mau_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [mau_pkg::COORD_W-1:0]       out_row;
  logic [mau_pkg::COORD_W-1:0]       out_col;
  logic signed [mau_pkg::DATA_W-1:0] out_value;
  logic                              last;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output last, input ready);
  modport sink   (input valid, input out_row, input out_col, input out_value,
                  input last, output ready);
endinterface

// File: rtl/matrix_arithmetic_unit.sv
// Matrix arithmetic unit: two matrix memories, operation sequencer and MAC pipeline.
//
//   channel | dir | transaction
//   --------+-----+-------------------------------------------------------------
//   req     | in  | func, row, col, value: load one entry or start an operation
//   rsp     | out | out_row, out_col, out_value, last: one result entry
//
// Sum, difference and scale emit one entry per cycle while rsp is not stalled; the
// product accumulates each entry over N terms in the single multiply-accumulate fed
// by one read port of each memory. Results pass through the memory read registers, the
// stage 2 register and the output register. After reset both memories are zeroed, one
// entry per cycle, with req.ready low. A stalled rsp freezes the whole read/compute pipeline.
module matrix_arithmetic_unit #(
  parameter int N = mau_pkg::DEFAULT_N
) (
  input  logic     clk,
  input  logic     rst,
  mau_req_if.sink   req,
  mau_rsp_if.source rsp
);

  localparam int CELLS = N * N;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(N);
  localparam int DW    = mau_pkg::DATA_W;
  localparam int CW    = mau_pkg::COORD_W;
  localparam int FW    = mau_pkg::FUNC_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  // Matrix storage.
  logic [DW-1:0] left_mem  [CELLS];
  logic [DW-1:0] right_mem [CELLS];

  // Control state.
  logic [1:0]    state;
  logic [AW-1:0] clr_addr;
  logic [FW-1:0] op_func;
  logic [DW-1:0] op_scalar;
  logic [IW-1:0] r, c, k;

  // Pipeline registers.
  logic          s1_v, s1_first, s1_lastk, s1_end;
  logic [IW-1:0] s1_r, s1_c;
  logic [DW-1:0] l_rd, r_rd;
  logic          s2_v, s2_first, s2_lastk, s2_end;
  logic [IW-1:0] s2_r, s2_c;
  logic [DW-1:0] s2_val;
  logic [DW-1:0] acc;
  logic          out_valid, out_last;
  logic [CW-1:0] out_row, out_col;
  logic [DW-1:0] out_value;

  logic          accept, adv, issue, is_prod, is_op, in_range;
  logic          k_end, c_end, r_end;
  logic [AW-1:0] ld_addr, elem_addr, l_raddr, r_raddr;
  logic          l_we, r_we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [DW-1:0] acc_sum;

  // Handshake and pipeline advance.
  assign req.ready = (state == ST_IDLE) && !s1_v && !s2_v;
  assign accept    = req.valid && req.ready;
  assign adv       = !out_valid || rsp.ready;
  assign issue     = (state == ST_RUN) && adv;

  assign is_prod = (op_func == mau_pkg::FUNC_PRODUCT);
  assign is_op   = (req.func == mau_pkg::FUNC_SUM) || (req.func == mau_pkg::FUNC_DIFF) ||
                   (req.func == mau_pkg::FUNC_SCALE) || (req.func == mau_pkg::FUNC_PRODUCT);

  // Load address and range check.
  assign in_range = (32'(req.row) < N) && (32'(req.col) < N);
  assign ld_addr  = AW'(32'(req.row) * N + 32'(req.col));

  // Write port of each memory: clearing pass or a load.
  assign l_we  = (state == ST_CLEAR) ||
                 (accept && in_range && (req.func == mau_pkg::FUNC_LOAD_LEFT));
  assign r_we  = (state == ST_CLEAR) ||
                 (accept && in_range && (req.func == mau_pkg::FUNC_LOAD_RIGHT));
  assign waddr = (state == ST_CLEAR) ? clr_addr : ld_addr;
  assign wdata = (state == ST_CLEAR) ? '0 : DW'(req.value);

  // Read addresses from the sequencer counters.
  assign elem_addr = AW'(r) * AW'(N) + AW'(c);
  assign l_raddr   = is_prod ? (AW'(r) * AW'(N) + AW'(k)) : elem_addr;
  assign r_raddr   = is_prod ? (AW'(k) * AW'(N) + AW'(c)) : elem_addr;

  assign k_end = !is_prod || (k == IW'(N - 1));
  assign c_end = (c == IW'(N - 1));
  assign r_end = (r == IW'(N - 1));

  always_ff @(posedge clk) begin
    if (l_we) begin
      left_mem[waddr] <= wdata;
    end
    if (r_we) begin
      right_mem[waddr] <= wdata;
    end
    if (adv) begin
      l_rd <= left_mem[l_raddr];
      r_rd <= right_mem[r_raddr];
    end
  end

  // Sequencer: clearing pass, idle, and issuing reads of one operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      r        <= '0;
      c        <= '0;
      k        <= '0;
      op_func  <= mau_pkg::FUNC_SUM;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && is_op) begin
            state     <= ST_RUN;
            op_func   <= req.func;
            op_scalar <= DW'(req.value);
            r         <= '0;
            c         <= '0;
            k         <= '0;
          end
        end
        ST_RUN: begin
          if (issue) begin
            if (!k_end) begin
              k <= k + IW'(1);
            end else begin
              k <= '0;
              if (!c_end) begin
                c <= c + IW'(1);
              end else begin
                c <= '0;
                if (!r_end) begin
                  r <= r + IW'(1);
                end else begin
                  state <= ST_IDLE;
                end
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Stage 1 flags travel with the memory read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first <= (k == '0);
      s1_lastk <= k_end;
      s1_end   <= c_end && r_end;
      s1_r     <= r;
      s1_c     <= c;
    end
  end

  // Stage 2: element-wise add, subtract or one multiply.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_first <= s1_first;
      s2_lastk <= s1_lastk;
      s2_end   <= s1_end;
      s2_r     <= s1_r;
      s2_c     <= s1_c;
      case (op_func)
        mau_pkg::FUNC_SUM:   s2_val <= l_rd + r_rd;
        mau_pkg::FUNC_DIFF:  s2_val <= l_rd - r_rd;
        mau_pkg::FUNC_SCALE: s2_val <= l_rd * op_scalar;
        default:             s2_val <= l_rd * r_rd;
      endcase
    end
  end

  // Stage 3: accumulate and the output register.
  assign acc_sum = (s2_first ? '0 : acc) + s2_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_v && s2_lastk;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_v) begin
      if (s2_lastk) begin
        out_value <= acc_sum;
        out_row   <= CW'(s2_r);
        out_col   <= CW'(s2_c);
        out_last  <= s2_end;
      end else begin
        acc <= acc_sum;
      end
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.out_row   = out_row;
  assign rsp.out_col   = out_col;
  assign rsp.out_value = $signed(out_value);
  assign rsp.last      = out_last;

endmodule
